@@ sv/swf_pkg.sv @@
// Package for the skyline window filter: sizes, entry type, helpers.
// No dependencies.
package swf_pkg;
   localparam int WindowDepth = 32;
   localparam int MaxKeywords = 8;
   localparam int IdWidth = 31;
   localparam int DistWidth = 8;
   localparam int AddrWidth = $clog2(WindowDepth);
   localparam int CountWidth = $clog2(WindowDepth + 1);
   localparam int KwWidth = 4;

   typedef struct packed {
      logic [IdWidth-1:0] node_id;
      logic [MaxKeywords-1:0][DistWidth-1:0] dists;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic last_candidate;
   } req_type;

   typedef struct packed {
      entry_type entry;
      logic last_entry;
      logic empty_set;
      logic overflowed;
   } rsp_type;

   // Clamp the keyword count into 1..MaxKeywords.
   function automatic logic [KwWidth-1:0] clamp_kw(input logic [KwWidth-1:0] kw);
      logic [KwWidth-1:0] r;
      r = kw;
      if (kw == '0) r = KwWidth'(1);
      if (kw > KwWidth'(MaxKeywords)) r = KwWidth'(MaxKeywords);
      return r;
   endfunction
endpackage

@@ sv/swf_if.sv @@
// Valid/ready channel carrying a typed payload.
// Depends on swf_pkg.
interface swf_req_if (input logic clock);
   import swf_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface swf_rsp_if (input logic clock);
   import swf_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/swf_window_ram.sv @@
// Window entry storage: one write port, one registered read port.
// Depends on swf_pkg.
module swf_window_ram (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [swf_pkg::AddrWidth-1:0] wr_addr,
   input  swf_pkg::entry_type       wr_data,
   input  logic [swf_pkg::AddrWidth-1:0] rd_addr,
   output swf_pkg::entry_type       rd_data
);
   import swf_pkg::*;
   entry_type mem [WindowDepth];

   // Write and read, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ sv/swf_compare.sv @@
// Dominance compare of a candidate against one entry over the first kw distances.
// Depends on swf_pkg.
module swf_compare (
   input  swf_pkg::entry_type        cand,
   input  swf_pkg::entry_type        entry,
   input  logic [swf_pkg::KwWidth-1:0] kw,
   output logic                      le,
   output logic                      ge,
   output logic                      eq
);
   import swf_pkg::*;
   always_comb begin
      le = 1'b1;
      ge = 1'b1;
      eq = 1'b1;
      for (int j = 0; j < MaxKeywords; j++) begin
         if (KwWidth'(j) < kw) begin
            if (cand.dists[j] > entry.dists[j]) le = 1'b0;
            if (cand.dists[j] < entry.dists[j]) ge = 1'b0;
            if (cand.dists[j] != entry.dists[j]) eq = 1'b0;
         end
      end
   end
endmodule

@@ sv/skyline_window_filter.sv @@
// Skyline window filter, top level: scan sequencer, window memory, result register.
// Depends on swf_pkg, swf_if, swf_window_ram, swf_compare.
//
// After its transfer a candidate holds the input until ready returns: the transfer is
// taken, the window memory is read entry by entry while survivors are compacted in
// place (the write pointer trails the read pointer, so removals cost nothing extra),
// the scan stops early at an equal or a dominating entry, and the scan is then closed
// and the survivor appended. A last candidate is then followed by a readout of one
// result per entry, each a memory read and then a result register load, and the
// readout waits while the receiver stalls. Window depth 32; a surviving candidate that
// finds the window still full after compaction is dropped and sets the sticky overflow
// flag reported with the next readout.
module skyline_window_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [swf_pkg::KwWidth-1:0] csr_wdata,
   swf_req_if.sink          req,
   swf_rsp_if.source        rsp
);
   import swf_pkg::*;

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StScan = 3'd1;
   localparam logic [2:0] StCopy = 3'd2;
   localparam logic [2:0] StRead = 3'd3;
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [KwWidth-1:0] kw_ff;
   entry_type cand_ff;
   logic last_ff;
   logic ovf_ff, ovf_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [CountWidth-1:0] rd_ff, rd_in;     // next entry address to read
   logic [CountWidth-1:0] wr_ff, wr_in;     // compaction write pointer
   logic pend_ff, pend_in;                  // read data valid this cycle
   logic keep_ff, keep_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic wr_en;
   logic [AddrWidth-1:0] wr_addr;
   logic [AddrWidth-1:0] rd_addr;
   entry_type wr_data, rd_data;
   logic le, ge, eq;

   // Hold the address of the entry being output while the result waits
   assign rd_addr = (state_ff == StOut) ? rd_ff[AddrWidth-1:0] - AddrWidth'(1)
                                        : rd_ff[AddrWidth-1:0];

   swf_window_ram u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   swf_compare u_cmp (
      .cand(cand_ff), .entry(rd_data), .kw(kw_ff), .le(le), .ge(ge), .eq(eq)
   );

   assign req.ready = (state_ff == StIdle);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_ff;

   // Hold the keyword count
   always_ff @(posedge clock) begin
      if (reset) kw_ff <= clamp_kw(KwWidth'(MaxKeywords));
      else if (csr_we) kw_ff <= clamp_kw(csr_wdata);
   end

   // Sequencer: scan with in-place compaction, then append, then readout after a last candidate
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      pend_in = 1'b0;
      keep_in = keep_ff;
      ovf_in = ovf_ff;
      wr_en = 1'b0;
      wr_addr = wr_ff[AddrWidth-1:0];
      wr_data = rd_data;
      case (state_ff)
         StIdle: begin
            if (req.valid) begin
               state_in = StScan;
               rd_in = '0;
               wr_in = '0;
               keep_in = 1'b1;
               pend_in = (count_ff != '0);
               if (count_ff != '0) rd_in = CountWidth'(1);
            end
         end
         StScan: begin
            if (pend_ff) begin
               if (eq || (ge && !le)) begin
                  // stop: keep this and all later entries, copy them down
                  if (!eq) keep_in = 1'b0;
                  wr_en = 1'b1;
                  wr_in = wr_ff + 1'b1;
                  state_in = StCopy;
                  pend_in = (rd_ff < count_ff);
                  if (rd_ff < count_ff) rd_in = rd_ff + 1'b1;
               end else begin
                  if (!le) begin
                     wr_en = 1'b1;
                     wr_in = wr_ff + 1'b1;
                  end
                  pend_in = (rd_ff < count_ff);
                  if (rd_ff < count_ff) rd_in = rd_ff + 1'b1;
               end
            end else begin
               state_in = StCopy;
            end
         end
         StCopy: begin
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_in = wr_ff + 1'b1;
               pend_in = (rd_ff < count_ff);
               if (rd_ff < count_ff) rd_in = rd_ff + 1'b1;
            end else begin
               // append the survivor; wr_ff is the compacted count
               count_in = wr_ff;
               if (keep_ff) begin
                  if (wr_ff < CountWidth'(WindowDepth)) begin
                     wr_en = 1'b1;
                     wr_data = cand_ff;
                     count_in = wr_ff + 1'b1;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               rd_in = '0;
               state_in = last_ff ? StRead : StIdle;
            end
         end
         StRead: begin
            // issue read of entry rd_ff
            pend_in = 1'b1;
            rd_in = rd_ff + 1'b1;
            state_in = StOut;
         end
         StOut: begin
            if (!rsp_valid_ff || rsp.ready) begin
               if (count_ff == '0 || rd_ff >= count_ff) begin
                  state_in = StIdle;
                  count_in = '0;
                  ovf_in = 1'b0;
               end else begin
                  state_in = StRead;
               end
            end else begin
               pend_in = pend_ff;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         rd_ff <= '0;
         wr_ff <= '0;
         pend_ff <= 1'b0;
         keep_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         pend_ff <= pend_in;
         keep_ff <= keep_in;
         rsp_valid_ff <= (rsp_valid_ff && !rsp.ready) ||
                         (state_ff == StOut && (!rsp_valid_ff || rsp.ready));
      end
   end

   // Capture the candidate and load the result register
   always_ff @(posedge clock) begin
      if (state_ff == StIdle && req.valid) begin
         cand_ff <= req.data.entry;
         last_ff <= req.data.last_candidate;
      end
      if (state_ff == StOut && (!rsp_valid_ff || rsp.ready)) begin
         rsp_ff.overflowed <= ovf_ff;
         if (count_ff == '0) begin
            rsp_ff.entry <= '0;
            rsp_ff.empty_set <= 1'b1;
            rsp_ff.last_entry <= 1'b1;
         end else begin
            rsp_ff.entry <= rd_data;
            rsp_ff.empty_set <= 1'b0;
            rsp_ff.last_entry <= (rd_ff >= count_ff);
         end
      end
   end
endmodule

@@ dv/swf_scoreboard.sv @@
// Scoreboard for the skyline window filter: window predictor and result check.
// Depends on swf_pkg.
package swf_scoreboard_pkg;
   import swf_pkg::*;

   class swf_scoreboard;
      entry_type window_q[$];
      bit overflow_flag;
      logic [KwWidth-1:0] num_keywords;
      rsp_type readout_q[$];
      int error_count;

      function void reset_state();
         window_q.delete();
         readout_q.delete();
         overflow_flag = 0;
         num_keywords = KwWidth'(MaxKeywords);
         error_count = 0;
      endfunction

      function void set_keywords(logic [KwWidth-1:0] value);
         num_keywords = value;
      endfunction

      // Scan the window, update it, and queue a readout on a last candidate.
      function void note_candidate(req_type item);
         int kw;
         int i;
         bit keep;
         bit le, ge, eq;
         rsp_type r;
         kw = (num_keywords == 0) ? 1 :
              (num_keywords > MaxKeywords) ? MaxKeywords : int'(num_keywords);
         keep = 1;
         i = 0;
         while (i < window_q.size()) begin
            le = 1; ge = 1; eq = 1;
            for (int j = 0; j < kw; j++) begin
               if (item.entry.dists[j] > window_q[i].dists[j]) le = 0;
               if (item.entry.dists[j] < window_q[i].dists[j]) ge = 0;
               if (item.entry.dists[j] != window_q[i].dists[j]) eq = 0;
            end
            if (eq) break;
            if (le) begin
               window_q.delete(i);
               continue;
            end
            if (ge) begin
               keep = 0;
               break;
            end
            i++;
         end
         if (keep) begin
            if (window_q.size() < WindowDepth) window_q.insert(window_q.size(), item.entry);
            else overflow_flag = 1;
         end
         if (!item.last_candidate) return;
         if (window_q.size() == 0) begin
            r = '0;
            r.last_entry = 1;
            r.empty_set = 1;
            r.overflowed = overflow_flag;
            readout_q.insert(readout_q.size(), r);
         end else begin
            foreach (window_q[k]) begin
               r.entry = window_q[k];
               r.last_entry = (k == window_q.size() - 1);
               r.empty_set = 0;
               r.overflowed = overflow_flag;
               readout_q.insert(readout_q.size(), r);
            end
         end
         window_q.delete();
         overflow_flag = 0;
      endfunction

      // Compare one result with the oldest expectation.
      function void check_result(rsp_type got);
         rsp_type want;
         if (readout_q.size() == 0) begin
            $error("unexpected result id %0h", got.entry.node_id);
            error_count++;
            return;
         end
         want = readout_q.pop_front();
         if (got.entry.node_id !== want.entry.node_id) begin
            $error("out_node_id: expected %0h actual %0h", want.entry.node_id,
                   got.entry.node_id);
            error_count++;
         end
         for (int j = 0; j < MaxKeywords; j++)
            if (got.entry.dists[j] !== want.entry.dists[j]) begin
               $error("out_dist_%0d: expected %0d actual %0d", j, want.entry.dists[j],
                      got.entry.dists[j]);
               error_count++;
            end
         if (got.last_entry !== want.last_entry) begin
            $error("last_entry: expected %0b actual %0b", want.last_entry, got.last_entry);
            error_count++;
         end
         if (got.empty_set !== want.empty_set) begin
            $error("empty_set: expected %0b actual %0b", want.empty_set, got.empty_set);
            error_count++;
         end
         if (got.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0b actual %0b", want.overflowed, got.overflowed);
            error_count++;
         end
      endfunction
   endclass
endpackage

@@ dv/testbench.sv @@
// Testbench for skyline_window_filter: random and directed candidates, scoreboard check.
// Depends on swf_pkg, swf_if, swf_scoreboard_pkg and the block's RTL.
module testbench;
   import swf_pkg::*;
   import swf_scoreboard_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [KwWidth-1:0] csr_wdata = '0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off = 0;
   swf_scoreboard skyline_sb;

   swf_req_if req (clock);
   swf_rsp_if rsp (clock);

   skyline_window_filter i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req(req), .rsp(rsp)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Bound the run.
   initial begin
      #40000000;
      $display("testbench: errors");
      $finish;
   end

   // Drain results with random stalls; hold off entirely when asked.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) skyline_sb.check_result(rsp.data);
      rsp.ready <= !reset && !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_keywords(logic [KwWidth-1:0] value);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      skyline_sb.set_keywords(value);
   endtask

   // Offer one candidate and hold it until transferred; valid drops on the next idle.
   task automatic send_candidate(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 0;
         @(posedge clock);
      end
      req.valid <= 1;
      req.data <= item;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      skyline_sb.note_candidate(item);
   endtask

   task automatic wait_drained();
      req.valid <= 0;
      while (skyline_sb.readout_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // Distances in a narrow range (full byte range when spread is zero) so that dominance and equality happen often.
   function automatic req_type make_candidate(bit last, int spread);
      req_type r;
      r.entry.node_id = 31'($urandom);
      for (int j = 0; j < MaxKeywords; j++)
         r.entry.dists[j] = (spread == 0) ? 8'($urandom) : 8'($urandom_range(spread));
      r.last_candidate = last;
      return r;
   endfunction

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      req_type r;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         r = make_candidate($urandom_range(7) == 0, ($urandom_range(9) == 0) ? 0 : 4);
         send_candidate(r);
      end
   endtask

   initial begin
      req_type r;
      req.valid = 0;
      req.data = '0;
      skyline_sb = new();
      skyline_sb.reset_state();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: single-entry readout, extremes, equal and dominated cases.
      r = '0; r.last_candidate = 1;
      send_candidate(r);
      r.entry.node_id = '1; r.entry.dists = '1; r.last_candidate = 0;
      send_candidate(r);
      r.entry.node_id = 31'h1; r.entry.dists = '1;
      send_candidate(r);
      r.entry.node_id = 31'h2; r.entry.dists = '0;
      send_candidate(r);
      r.entry.node_id = 31'h3; r.entry.dists = '1; r.last_candidate = 1;
      send_candidate(r);
      r.entry.node_id = 31'h4;
      r.entry.dists = {8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd9};
      r.last_candidate = 0;
      send_candidate(r);
      r.entry.node_id = 31'h5;
      r.entry.dists = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd8};
      r.last_candidate = 1;
      send_candidate(r);
      wait_drained();

      // Fill past the window depth with mutually incomparable candidates.
      write_keywords(4'd2);
      for (int k = 0; k < WindowDepth + 3; k++) begin
         r.entry.node_id = 31'(k);
         r.entry.dists = '0;
         r.entry.dists[0] = 8'(k);
         r.entry.dists[1] = 8'(200 - k);
         r.last_candidate = (k == WindowDepth + 2);
         send_candidate(r);
      end
      wait_drained();

      // Random phases across keyword counts, including out-of-range values.
      write_keywords(4'd1);
      random_phase(30, 0, 0);
      send_candidate(make_candidate(1, 4));
      wait_drained();
      write_keywords(4'd8);
      random_phase(30, 65, 0);
      send_candidate(make_candidate(1, 4));
      wait_drained();
      write_keywords(4'd0);
      random_phase(30, 0, 65);
      send_candidate(make_candidate(1, 4));
      wait_drained();
      write_keywords(4'd15);
      random_phase(30, 9, 9);
      send_candidate(make_candidate(1, 4));
      wait_drained();
      write_keywords(4'd3);

      // Receiver holds off while candidates keep coming.
      hold_off = 1;
      fork
         begin
            repeat (1500) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_candidate(make_candidate(1, 4));
            random_phase(40, 0, 0);
         end
      join
      send_candidate(make_candidate(1, 0));
      wait_drained();
      write_keywords(4'd8);
      random_phase(20, 30, 30);
      send_candidate(make_candidate(1, 4));
      wait_drained();

      if (skyline_sb.error_count == 0 && skyline_sb.readout_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
